[hdl/olar_pkg.sv]
// Package for the ordered list block: status and operation codes, the default
// depth and the structs passed between the list cells and the top level.
// No dependencies.
package olar_pkg;

    localparam int unsigned OLAR_DEPTH = 16;
    localparam int unsigned VALUE_W    = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_APPENDED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Operation broadcast to every cell in the accepting cycle.
    typedef struct packed {
        logic                       do_append;
        logic                       do_remove;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_cmd;

    // Passed from a cell toward the tail.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_fwd_link;

    // Passed from a cell toward the head.
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
    } t_back_link;

endpackage

[hdl/olar_if.sv]
// Handshake interfaces for the ordered list block: the operation channel and
// the result channel. Depends on olar_pkg.
interface olar_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [olar_pkg::VALUE_W-1:0]  item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface olar_out_if #(
    parameter int unsigned COUNT_W = 5
);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

[hdl/olar_cell.sv]
// One position of the ordered list: holds a value and its valid flag.
// Depends on olar_pkg.
module olar_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  olar_pkg::t_cell_cmd    i_cmd,
    input  olar_pkg::t_fwd_link    i_prev,
    input  olar_pkg::t_back_link   i_next,
    output olar_pkg::t_fwd_link    o_fwd,
    output olar_pkg::t_back_link   o_back
);
    import olar_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      match;

    assign match       = r_valid && (r_value == i_cmd.value);
    assign o_fwd.valid = r_valid;
    // Once a match is seen at or ahead of this cell, every cell from there on
    // takes its neighbor's contents to close the gap.
    assign o_fwd.hit   = i_prev.hit | match;
    assign o_back.valid = r_valid;
    assign o_back.value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.do_append && !r_valid && i_prev.valid) begin
            n_valid = 1'b1;
            n_value = i_cmd.value;
        end else if (i_cmd.do_remove && o_fwd.hit) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

[hdl/ordered_list_append_remove.sv]
// Ordered list of up to DEPTH signed 32-bit values: append at tail, remove
// first match. Top level; depends on olar_pkg, olar_if and olar_cell.
//
// Usage:
//   i_item carries an operation (opcode append or remove) and a value.
//   o_result returns one item per operation: a status code and the number
//   of entries held afterwards.
//   An operation is accepted whenever the result register is empty or is
//   being emptied in the same cycle, so one item per cycle flows through
//   when the receiver keeps ready high.
//   The result is registered: it appears the cycle after acceptance.
//   All cells compare against the value at once; the first-match flag
//   ripples down the cell row in the accepting cycle, and the list shifts
//   toward the head in the same clock edge that registers the result.
//   If the receiver stalls, the result is held and no new operation is
//   accepted until it has been taken.
//   Reset empties the list and the result register; the stored values are
//   left as they are, since only valid positions are ever compared.
//   An append to a full list returns the full status and changes nothing;
//   a remove without a match returns not found.
module ordered_list_append_remove #(
    parameter int unsigned DEPTH   = olar_pkg::OLAR_DEPTH,
    parameter int unsigned COUNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    olar_in_if.sink           i_item,
    olar_out_if.source        o_result
);
    import olar_pkg::*;

    t_cell_cmd           cmd;
    t_fwd_link           fwd  [DEPTH+1];
    t_back_link          back [DEPTH+1];
    logic                accept;
    logic                full;
    logic                found;

    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign cmd.do_append = accept && (i_item.opcode == OP_APPEND);
    assign cmd.do_remove = accept && (i_item.opcode == OP_REMOVE);
    assign cmd.value     = i_item.item_value;

    assign fwd[0].valid      = 1'b1;
    assign fwd[0].hit        = 1'b0;
    assign back[DEPTH].valid = 1'b0;
    assign back[DEPTH].value = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        olar_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_prev  (fwd[g]),
            .i_next  (back[g+1]),
            .o_fwd   (fwd[g+1]),
            .o_back  (back[g])
        );
    end

    assign full  = fwd[DEPTH].valid;
    assign found = fwd[DEPTH].hit;

    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        if (accept) begin
            if (i_item.opcode == OP_APPEND) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_APPENDED;
                    n_count  = r_count + COUNT_W'(1);
                end
            end else begin
                if (found) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - COUNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_status <= n_status;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_status;
    assign o_result.entry_count = r_count;

endmodule

[hdl/olar_checker.sv]
// Port-level checks for the ordered list block, bound to its top level.
// Depends on olar_pkg and olar_if.
module olar_checker #(
    parameter int unsigned DEPTH   = olar_pkg::OLAR_DEPTH,
    parameter int unsigned COUNT_W = $clog2(DEPTH + 1)
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_status,
    input logic [COUNT_W-1:0] i_entry_count
);
    import olar_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_entry_count))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_entry_count <= COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_entry_count == COUNT_W'(DEPTH))
        else $error("full status with list not full");

    a_append_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_APPENDED |-> i_entry_count != '0)
        else $error("append reported with empty list");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind ordered_list_append_remove olar_checker #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_W)
) u_olar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_entry_count (o_result.entry_count)
);

[test/tb_ordered_list_append_remove.sv]
// Testbench for ordered_list_append_remove: directed table, then random append/remove
// traffic checked against an in-bench list predictor, with random stalls on both channels.
// Depends on olar_pkg, olar_if and the ordered_list_append_remove RTL.
module tb_ordered_list_append_remove;
    timeunit 1ns;
    timeprecision 1ps;

    import olar_pkg::*;

    localparam int COUNT_W      = 5;
    localparam int RANDOM_ITEMS = 1870;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 400;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } list_result_t;

    // One directed row; reps > 1 repeats the operation with value, value+1, ...
    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic [4:0]                reps;
        logic                      typed;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        entry_count;
    } op_row_t;

    localparam int N_ROWS = 19;
    localparam op_row_t DIRECTED_OPS [N_ROWS] = '{
        '{OP_REMOVE, 32'sd0,   5'd1,  1'b1, ST_NOT_FOUND, 5'd0},
        '{OP_APPEND, VAL_MIN,  5'd1,  1'b1, ST_APPENDED,  5'd1},
        '{OP_APPEND, VAL_MAX,  5'd1,  1'b1, ST_APPENDED,  5'd2},
        '{OP_REMOVE, VAL_MAX,  5'd1,  1'b1, ST_REMOVED,   5'd1},
        '{OP_REMOVE, VAL_MIN,  5'd1,  1'b1, ST_REMOVED,   5'd0},
        '{OP_APPEND, 32'sd5,   5'd1,  1'b1, ST_APPENDED,  5'd1},
        '{OP_REMOVE, 32'sd5,   5'd1,  1'b1, ST_REMOVED,   5'd0},
        '{OP_APPEND, -32'sd1,  5'd1,  1'b1, ST_APPENDED,  5'd1},
        '{OP_APPEND, 32'sd0,   5'd1,  1'b1, ST_APPENDED,  5'd2},
        '{OP_APPEND, -32'sd1,  5'd1,  1'b1, ST_APPENDED,  5'd3},
        '{OP_REMOVE, -32'sd1,  5'd1,  1'b1, ST_REMOVED,   5'd2},
        '{OP_REMOVE, 32'sd1,   5'd1,  1'b1, ST_NOT_FOUND, 5'd2},
        '{OP_APPEND, 32'sd100, 5'd14, 1'b0, ST_APPENDED,  5'd0},
        '{OP_APPEND, 32'sd7,   5'd1,  1'b1, ST_FULL,      5'd16},
        '{OP_REMOVE, 32'sd7,   5'd1,  1'b1, ST_NOT_FOUND, 5'd16},
        '{OP_REMOVE, 32'sd106, 5'd1,  1'b0, ST_REMOVED,   5'd0},
        '{OP_REMOVE, -32'sd1,  5'd1,  1'b0, ST_REMOVED,   5'd0},
        '{OP_REMOVE, 32'sd0,   5'd1,  1'b0, ST_REMOVED,   5'd0},
        '{OP_APPEND, VAL_MAX,  5'd3,  1'b0, ST_APPENDED,  5'd0}
    };

    logic i_clk;
    logic i_rst_n;

    olar_in_if                      in_ch ();
    olar_out_if #(.COUNT_W(COUNT_W)) out_ch ();

    ordered_list_append_remove #(
        .DEPTH   (OLAR_DEPTH),
        .COUNT_W (COUNT_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    logic signed [VALUE_W-1:0] held_values [$];
    list_result_t              expected_results [$];
    int                        status_tally [4];
    int                        mismatches;
    int                        results_seen;
    int                        idle_cycles;
    logic                      steady_run;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Applies one operation to the predicted list and returns the status and entry count it yields.
    function automatic list_result_t apply_list_op(input logic op,
                                                   input logic signed [VALUE_W-1:0] value);
        list_result_t r;
        int           hit_at;
        hit_at = -1;
        if (op == OP_APPEND) begin
            if (held_values.size() >= OLAR_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                held_values.push_back(value);
                r.status = ST_APPENDED;
            end
        end else begin
            foreach (held_values[i]) begin
                if (hit_at < 0 && held_values[i] == value) hit_at = i;
            end
            if (hit_at >= 0) begin
                held_values.delete(hit_at);
                r.status = ST_REMOVED;
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.entry_count = COUNT_W'(held_values.size());
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Small values make duplicates and repeat hits likely; the rest spans all 32 bits.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $signed($urandom_range(0, 6)) - 3;
        if (r < 35) return VAL_MIN;
        if (r < 40) return VAL_MAX;
        return $signed($urandom());
    endfunction

    task automatic send_operation(input logic op, input logic signed [VALUE_W-1:0] value,
                                  input logic typed, input list_result_t typed_result);
        int           gap;
        list_result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.item_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = apply_list_op(op, value);
        if (typed) begin
            expected_results.push_back(typed_result);
            status_tally[typed_result.status]++;
        end else begin
            expected_results.push_back(predicted);
            status_tally[predicted.status]++;
        end
    endtask

    // Result side: check each accepted item, then choose ready for the next edge.
    initial begin
        int           hold_left;
        logic         hold_done;
        list_result_t exp_res;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d, entry_count %0d",
                           out_ch.status, out_ch.entry_count);
                    mismatches++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (out_ch.status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.entry_count !== exp_res.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_res.entry_count, out_ch.entry_count);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // One long hold-off so the sender backs up against a full result register.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                hold_left = pick_gap();
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("ordered_list_append_remove test failed");
            $finish;
        end
    end

    initial begin
        list_result_t              typed_res;
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic                      filling;
        int                        fill;
        foreach (status_tally[i]) status_tally[i] = 0;
        filling          = 1'b1;
        i_rst_n          <= 1'b0;
        steady_run       <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_APPEND;
        in_ch.item_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_OPS[r]) begin
            for (int k = 0; k < DIRECTED_OPS[r].reps; k++) begin
                typed_res.status      = DIRECTED_OPS[r].status;
                typed_res.entry_count = DIRECTED_OPS[r].entry_count;
                send_operation(DIRECTED_OPS[r].op, DIRECTED_OPS[r].value + k,
                               DIRECTED_OPS[r].typed, typed_res);
            end
        end

        // Random part: the list drifts between empty and full; most removes target
        // a value that is actually held so hits land at every position.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 120 == 0) steady_run <= ($urandom_range(0, 3) == 0);
            fill = held_values.size();
            if (fill == 0) filling = 1'b1;
            if (fill >= OLAR_DEPTH && $urandom_range(0, 2) != 0) filling = 1'b0;
            if ($urandom_range(0, 49) == 0) filling = ~filling;
            op = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? OP_APPEND : OP_REMOVE;
            if (op == OP_REMOVE && fill > 0 && $urandom_range(0, 99) < 70) begin
                value = held_values[$urandom_range(0, fill - 1)];
            end else begin
                value = pick_value();
            end
            typed_res = '0;
            send_operation(op, value, 1'b0, typed_res);
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Covered %0d list operations: %0d appended, %0d removed, %0d not found,",
                 results_seen, status_tally[ST_APPENDED], status_tally[ST_REMOVED],
                 status_tally[ST_NOT_FOUND]);
        $display("%0d appends dropped on a full list, %0d field mismatches.",
                 status_tally[ST_FULL], mismatches);
        if (mismatches == 0) begin
            $display("ordered_list_append_remove test passed");
        end else begin
            $display("ordered_list_append_remove test failed");
        end
        $finish;
    end

endmodule
